// File: rtl/pto_pkg.sv
// Package for the pulser time offset accumulator: opcodes, CSR indices, limits and the window type.
// Used by pto_acc_step and pulser_time_offset_accumulator.
`timescale 1ns / 1ps
package pto_pkg;
   localparam logic [2:0] OP_HIT   = 3'd0;
   localparam logic [2:0] OP_LOAD  = 3'd1;
   localparam logic [2:0] OP_READ  = 3'd2;
   localparam logic [2:0] OP_RUN   = 3'd3;
   localparam logic [2:0] OP_CLEAR = 3'd4;

   localparam logic [1:0] CSR_NMOD = 2'd0;
   localparam logic [1:0] CSR_GAP  = 2'd1;
   localparam logic [1:0] CSR_WLO  = 2'd2;
   localparam logic [1:0] CSR_WHI  = 2'd3;

   localparam logic [63:0] SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SUM_MIN = 64'h8000_0000_0000_0000;
   localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [40:0] win_lo;
      logic [40:0] win_hi;
   } window_type;
endpackage

// File: rtl/pulser_time_offset_accumulator.sv
// Top level of the pulser time offset accumulator: tables, sequencer and
// configuration registers. Depends on pto_pkg and pto_acc_step.
`timescale 1ns / 1ps
// Usage: items enter on the req_ channel (valid/ready) and each produces one
// beat on the rsp_ channel. Configuration is written through csr_we/csr_index/
// csr_wdata; the user must do so only while the block is idle, which the block itself does not enforce.
// Sequencing: hits that are not a triggering pulser hit, loads, reads and
// opcodes without effect go from accept through the EXEC state to a result beat. A
// triggering pulser hit then walks the modules one per cycle through a single
// shared subtract/compare/accumulate unit in the WALK state before its result beat.
// New run and clear sums sweep all MAX_MODULES table entries one module per cycle
// in the SWEEP state before their result beat. One item is in flight at a time.
// Issue: the next item is accepted at the earliest in the cycle after the result
// beat is taken, so items never overlap.
// The result sits in an output register; while the receiver stalls the
// block holds it and accepts no new item.
// Reset returns registers to their reset values and clears the tables by a
// sweep over all MAX_MODULES entries during which no item is accepted.
module pulser_time_offset_accumulator
   import pto_pkg::*;
#(
   parameter int MAX_MODULES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_module_req,
   input  logic [7:0]  req_channel,
   input  logic [62:0] req_timestamp_ps,
   input  logic        req_pulser_enable,
   input  logic [7:0]  req_pulser_channel,
   input  logic [31:0] req_pulser_delay_ps,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic [7:0]  rsp_module_out,
   output logic [63:0] rsp_offset_sum_ps,
   output logic [31:0] rsp_entry_count,
   output logic        rsp_accumulated,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [40:0] csr_wdata
);
   localparam int AW = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;
   localparam int CW = AW + 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EXEC  = 3'd1;
   localparam logic [2:0] ST_WALK  = 3'd2;
   localparam logic [2:0] ST_SWEEP = 3'd3;
   localparam logic [2:0] ST_RESP  = 3'd4;

   // tables
   logic        ptab_en   [MAX_MODULES];
   logic [7:0]  ptab_ch   [MAX_MODULES];
   logic [31:0] ptab_dly  [MAX_MODULES];
   logic [63:0] ptime     [MAX_MODULES];
   logic [63:0] sum_mem   [MAX_MODULES];
   logic [31:0] cnt_mem   [MAX_MODULES];

   logic [2:0]  state_ff;
   logic [CW-1:0] idx_ff;
   logic [CW-1:0] nlim_ff;
   logic        sw_time_ff, sw_sum_ff;
   logic [2:0]  op_ff;
   logic [7:0]  mod_ff, ch_ff;
   logic [62:0] ts_ff;
   logic        pen_ff;
   logic [7:0]  pch_ff;
   logic [31:0] pdly_ff;
   logic [63:0] prev_time_ff;
   logic        prev_valid_ff;
   logic [4:0]  nmod_ff;
   logic [39:0] gap_ff;
   window_type  win_ff;
   logic        st_ff, acc_ff;
   logic [63:0] sum_o_ff;
   logic [31:0] cnt_o_ff;

   logic [8:0]  ncount;
   logic        in_range;
   logic [AW-1:0] ma;
   logic [AW-1:0] wa;
   logic        take;
   logic [63:0] sum_nx;
   logic [31:0] cnt_nx;
   logic        is_pulser;
   logic [63:0] gdiff;
   logic        trig;
   logic        exec_bad;
   logic        exec_pulse;
   logic        exec_walk;
   logic        exec_load;
   logic        exec_read;
   logic        exec_run;
   logic        exec_clr;

   always_comb begin
      ncount = ({4'd0, nmod_ff} > 9'(MAX_MODULES)) ? 9'(MAX_MODULES) : {4'd0, nmod_ff};
      in_range = {1'b0, mod_ff} < ncount;
      ma = mod_ff[AW-1:0];
      wa = idx_ff[AW-1:0];
      is_pulser = in_range && ptab_en[ma] && (ptab_ch[ma] == ch_ff);
      gdiff = {1'b0, ts_ff} - prev_time_ff;
      trig = prev_valid_ff && !gdiff[63] && (gdiff >= {24'd0, gap_ff});
      exec_bad = (op_ff <= OP_READ) && !in_range;
      exec_pulse = (op_ff == OP_HIT) && is_pulser;
      exec_walk = exec_pulse && trig;
      exec_load = (op_ff == OP_LOAD) && in_range;
      exec_read = (op_ff == OP_READ) && in_range;
      exec_run = (op_ff == OP_RUN);
      exec_clr = (op_ff == OP_CLEAR);
   end

   pto_acc_step u_step (
      .time_j (ptime[wa]),
      .time_0 (ptime[0]),
      .win    (win_ff),
      .sum_in (sum_mem[wa]),
      .cnt_in (cnt_mem[wa]),
      .take   (take),
      .sum_out(sum_nx),
      .cnt_out(cnt_nx)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_status = st_ff;
   assign rsp_module_out = mod_ff;
   assign rsp_offset_sum_ps = sum_o_ff;
   assign rsp_entry_count = cnt_o_ff;
   assign rsp_accumulated = acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         nmod_ff <= 5'd16;
         gap_ff <= 40'd10000000;
         win_ff.win_lo <= -41'sd5000000;
         win_ff.win_hi <= 41'sd5000000;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NMOD: nmod_ff <= csr_wdata[4:0];
            CSR_GAP:  gap_ff <= csr_wdata[39:0];
            CSR_WLO:  win_ff.win_lo <= csr_wdata;
            CSR_WHI:  win_ff.win_hi <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         idx_ff <= '0;
         nlim_ff <= CW'(MAX_MODULES);
         sw_time_ff <= 1'b1;
         sw_sum_ff <= 1'b1;
         prev_time_ff <= '0;
         prev_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  op_ff <= req_opcode;
                  mod_ff <= req_module_req;
                  ch_ff <= req_channel;
                  ts_ff <= req_timestamp_ps;
                  pen_ff <= req_pulser_enable;
                  pch_ff <= req_pulser_channel;
                  pdly_ff <= req_pulser_delay_ps;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               st_ff <= exec_bad;
               acc_ff <= exec_walk;
               sum_o_ff <= exec_read ? sum_mem[ma] : '0;
               cnt_o_ff <= exec_read ? cnt_mem[ma] : '0;
               idx_ff <= '0;
               nlim_ff <= exec_walk ? ncount[CW-1:0] : CW'(MAX_MODULES);
               sw_time_ff <= exec_run;
               sw_sum_ff <= exec_clr;
               if (exec_walk) begin
                  state_ff <= ST_WALK;
               end else if (exec_run || exec_clr) begin
                  state_ff <= ST_SWEEP;
               end else begin
                  state_ff <= ST_RESP;
               end
               if (exec_pulse) begin
                  ptime[ma] <= {1'b0, ts_ff} - {32'd0, ptab_dly[ma]};
                  prev_time_ff <= {1'b0, ts_ff};
                  prev_valid_ff <= 1'b1;
               end else if (exec_run) begin
                  prev_time_ff <= '0;
                  prev_valid_ff <= 1'b0;
               end
               if (exec_load) begin
                  ptab_en[ma] <= pen_ff;
                  ptab_ch[ma] <= pch_ff;
                  ptab_dly[ma] <= pdly_ff;
               end
            end
            ST_WALK: begin
               if (take) begin
                  sum_mem[wa] <= sum_nx;
                  cnt_mem[wa] <= cnt_nx;
               end
               idx_ff <= idx_ff + CW'(1);
               if (idx_ff + CW'(1) >= nlim_ff) state_ff <= ST_RESP;
            end
            ST_SWEEP: begin
               // Reset also clears the pulser setting tables.
               if (sw_time_ff) ptime[wa] <= '0;
               if (sw_sum_ff) begin
                  sum_mem[wa] <= '0;
                  cnt_mem[wa] <= '0;
               end
               if (sw_time_ff && sw_sum_ff) begin
                  ptab_en[wa] <= 1'b0;
                  ptab_ch[wa] <= '0;
                  ptab_dly[wa] <= '0;
               end
               idx_ff <= idx_ff + CW'(1);
               if (idx_ff + CW'(1) >= nlim_ff) begin
                  state_ff <= (sw_time_ff && sw_sum_ff) ? ST_IDLE : ST_RESP;
               end
            end
            ST_RESP: begin
               if (rsp_ready) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");
   a_walk_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (idx_ff < nlim_ff)) else $error("walk index overrun");
   a_acc_walk: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_accumulated) |-> (rsp_status == 1'b0))
      else $error("accumulated with bad status");
endmodule

// File: rtl/pto_acc_step.sv
// One walk step: offset of a module against module 0, window test and
// saturating accumulate. Depends on pto_pkg.
`timescale 1ns / 1ps
module pto_acc_step
   import pto_pkg::*;
(
   input  logic [63:0] time_j,
   input  logic [63:0] time_0,
   input  window_type  win,
   input  logic [63:0] sum_in,
   input  logic [31:0] cnt_in,
   output logic        take,
   output logic [63:0] sum_out,
   output logic [31:0] cnt_out
);
   logic [64:0] diff;
   logic        fits;
   logic [64:0] lo_x;
   logic [64:0] hi_x;
   logic [64:0] s;

   always_comb begin
      diff = {time_j[63], time_j} - {time_0[63], time_0};
      fits = (diff[64] == diff[63]);
      lo_x = {{24{win.win_lo[40]}}, win.win_lo};
      hi_x = {{24{win.win_hi[40]}}, win.win_hi};
      take = fits && !($signed(diff) < $signed(lo_x)) && ($signed(diff) < $signed(hi_x))
         && (cnt_in != CNT_MAX);
      s = {sum_in[63], sum_in} + diff;
      if (s[64] != s[63]) begin
         sum_out = s[64] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_out = s[63:0];
      end
      cnt_out = cnt_in + 32'd1;
   end
endmodule
